// ===== design/gsca_pkg.sv =====
// package: shared constants, types and register indexes of the concentration averager
`default_nettype none
package gsca_pkg;

  localparam int AdcBitsDefault   = 12;
  localparam int CountBitsDefault = 10;

  localparam int SupplyBits = 13;
  localparam int CfgBits    = 20;
  localparam int CfgIdxBits = 3;
  localparam int OhmBits    = 33;
  localparam int RatioBits  = 20;
  localparam int ConcBits   = 14;
  localparam int ConcMax    = 10000;
  localparam int RatioFrac  = 12;
  localparam int OutDataBits = 72;

  localparam logic [CfgIdxBits-1:0] CFG_SUPPLY    = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_LOAD      = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_RATIO_Z   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_RATIO_T   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_CAL_CNT   = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_MEAS_CNT  = 3'd5;

  localparam logic [SupplyBits-1:0] SupplyReset = 13'd3300;
  localparam logic [CfgBits-1:0]    LoadReset   = 20'd10000;
  localparam logic [CfgBits-1:0]    RatioZReset = 20'd4096;
  localparam logic [CfgBits-1:0]    RatioTReset = 20'd492;
  localparam int                    CalCntReset = 200;
  localparam int                    MeasCntReset = 150;

  localparam logic                  MODE_CAL  = 1'b0;
  localparam logic                  MODE_MEAS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VS,
    ST_CLAMP,
    ST_NUM,
    ST_RSDIV,
    ST_POST,
    ST_R0,
    ST_RATIO,
    ST_MAPMUL,
    ST_MAPDIV,
    ST_ACC,
    ST_AVG,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// ===== design/gas_sensor_concentration_averager.sv =====
// top level: sequenced rs/r0 ratio calibration and window averaging
//
// Samples are taken one at a time; s_axis_tready is high only while the sequencer idles.
// One shared multiplier (one product per cycle) and one shared restoring divider
// (one quotient bit per cycle, 45 bits by default) do all the arithmetic.
// A calibration sample that does not close its window needs no division; one that closes it
// takes up to two divisions. A measurement sample takes up to three divisions, four when
// it closes its window; a zero numerator or a ratio outside the map range skips a division.
// A finished result sits in the output register while the next sample is accepted.
`default_nettype none
module gas_sensor_concentration_averager
  import gsca_pkg::*;
#(
  parameter int ADC_BITS   = AdcBitsDefault,
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // adc_sample, zero padded
  input  wire logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // reference_ohms, concentration, last_ratio, zero padded
  output logic [OutDataBits-1:0]             m_axis_tdata,
  // result_kind
  output logic                               m_axis_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]         cfg_index_i,
  input  wire logic [CfgBits-1:0]            cfg_data_i
);

  localparam int VW  = ADC_BITS + SupplyBits;
  localparam int AW  = (VW > CfgBits) ? VW : CfgBits;
  localparam int PW  = AW + CfgBits;
  localparam int DW  = (OhmBits + ADC_BITS > OhmBits + RatioFrac) ?
                       OhmBits + ADC_BITS : OhmBits + RatioFrac;
  localparam int SW  = ((ADC_BITS > ConcBits) ? ADC_BITS : ConcBits) + COUNT_BITS;
  localparam int CW  = $clog2(DW + 1);
  localparam logic [ADC_BITS-1:0] FullScale = '1;

  // configuration
  logic [SupplyBits-1:0] supply_q;
  logic [CfgBits-1:0]    load_q, rz_q, rt_q;
  logic [COUNT_BITS-1:0] ccnt_q, mcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SupplyReset;
      load_q   <= LoadReset;
      rz_q     <= RatioZReset;
      rt_q     <= RatioTReset;
      ccnt_q   <= COUNT_BITS'(CalCntReset);
      mcnt_q   <= COUNT_BITS'(MeasCntReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SUPPLY:   supply_q <= cfg_data_i[SupplyBits-1:0];
        CFG_LOAD:     load_q   <= cfg_data_i;
        CFG_RATIO_Z:  rz_q     <= cfg_data_i;
        CFG_RATIO_T:  rt_q     <= cfg_data_i;
        CFG_CAL_CNT:  ccnt_q   <= cfg_data_i[COUNT_BITS-1:0];
        CFG_MEAS_CNT: mcnt_q   <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // datapath and control registers
  state_e                state_q, state_d;
  logic                  mode_q, wmode_q;
  logic [ADC_BITS-1:0]   lvl_q;
  logic [VW-1:0]         vs_q;
  logic [PW-1:0]         prod_q;
  logic [OhmBits-1:0]    rs_q, r0_q;
  logic [RatioBits-1:0]  ratio_q;
  logic [ConcBits-1:0]   conc_q;
  logic [SW-1:0]         sum_q;
  logic [COUNT_BITS-1:0] fill_q;
  logic                  out_valid_q;
  logic [OutDataBits-1:0] out_data_q;
  logic                  out_kind_q;

  // shared divider
  logic [DW-1:0]         dq_q;
  logic [OhmBits-1:0]    rem_q, dvs_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, done_q;
  logic                  div_go, div_take;
  logic [DW-1:0]         div_dvd;
  logic [OhmBits-1:0]    div_dvs;
  logic [OhmBits:0]      trial, trial_sub;
  logic                  trial_ge;

  assign trial     = {rem_q, dq_q[DW-1]};
  assign trial_ge  = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (div_go) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q - 1'b1;
    end else if (div_take) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      dq_q  <= div_dvd;
      dvs_q <= div_dvs;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= trial_ge ? trial_sub[OhmBits-1:0] : trial[OhmBits-1:0];
      dq_q  <= {dq_q[DW-2:0], trial_ge};
    end
  end

  // combinational helpers
  logic [VW-1:0]         top;
  logic [AW-1:0]         mul_a;
  logic [CfgBits-1:0]    mul_b;
  logic [PW-1:0]         mul_p;
  logic [CfgBits:0]      diff, span;
  logic [CfgBits-1:0]    diff_mag, span_mag;
  logic [COUNT_BITS-1:0] fill_n, limit;
  logic                  win_full;
  logic [SW-1:0]         acc_val;

  assign mul_p    = mul_a * mul_b;
  assign top      = {supply_q, {ADC_BITS{1'b0}}} - VW'(supply_q);
  assign diff     = {1'b0, ratio_q} - {1'b0, rz_q};
  assign span     = {1'b0, rt_q} - {1'b0, rz_q};
  assign diff_mag = diff[CfgBits] ? CfgBits'(-diff) : diff[CfgBits-1:0];
  assign span_mag = span[CfgBits] ? CfgBits'(-span) : span[CfgBits-1:0];
  assign fill_n   = ((fill_q + 1'b1) == '0) ? '1 : fill_q + 1'b1;
  assign limit    = ((mode_q ? mcnt_q : ccnt_q) == '0) ? COUNT_BITS'(1)
                                                      : (mode_q ? mcnt_q : ccnt_q);
  assign win_full = fill_n >= limit;
  assign acc_val  = mode_q ? SW'(conc_q) : SW'(lvl_q);

  always_comb begin
    state_d  = state_q;
    div_go   = 1'b0;
    div_take = 1'b0;
    div_dvd  = DW'(prod_q);
    div_dvs  = OhmBits'(vs_q);
    mul_a    = AW'(lvl_q);
    mul_b    = CfgBits'(supply_q);
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = s_axis_tuser ? ST_VS : ST_ACC;
      ST_VS:     state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_NUM;
      ST_NUM: begin
        mul_a = AW'(top - vs_q);
        mul_b = load_q;
        state_d = (top <= vs_q) ? ST_POST : ST_RSDIV;
      end
      ST_RSDIV: begin
        if (done_q) begin
          div_take = 1'b1;
          state_d  = ST_POST;
        end else if (!busy_q) begin
          div_go = 1'b1;
        end
      end
      ST_POST:   state_d = mode_q ? ST_RATIO : ST_R0;
      ST_R0:     state_d = ST_EMIT;
      ST_RATIO: begin
        div_dvd = DW'({rs_q, {RatioFrac{1'b0}}});
        div_dvs = r0_q;
        if (done_q) begin
          div_take = 1'b1;
          state_d  = ST_MAPMUL;
        end else if (!busy_q) begin
          div_go = 1'b1;
        end
      end
      ST_MAPMUL: begin
        mul_a = AW'(diff_mag);
        mul_b = CfgBits'(ConcMax);
        if (span == '0 || diff == '0 || diff[CfgBits] != span[CfgBits]) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_MAPDIV;
        end
      end
      ST_MAPDIV: begin
        div_dvs = OhmBits'(span_mag);
        if (done_q) begin
          div_take = 1'b1;
          state_d  = ST_ACC;
        end else if (!busy_q) begin
          div_go = 1'b1;
        end
      end
      ST_ACC:    state_d = win_full ? ST_AVG : ST_IDLE;
      ST_AVG: begin
        div_dvd = DW'(sum_q);
        div_dvs = OhmBits'(fill_q);
        if (done_q) begin
          div_take = 1'b1;
          state_d  = mode_q ? ST_EMIT : ST_VS;
        end else if (!busy_q) begin
          div_go = 1'b1;
        end
      end
      ST_EMIT:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wmode_q     <= MODE_CAL;
      sum_q       <= '0;
      fill_q      <= '0;
      r0_q        <= OhmBits'(1);
      ratio_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tuser != wmode_q) begin
            wmode_q <= s_axis_tuser;
            sum_q   <= '0;
            fill_q  <= '0;
          end
        end
        ST_RATIO: begin
          if (done_q) begin
            ratio_q <= (dq_q > DW'({RatioBits{1'b1}})) ? '1 : dq_q[RatioBits-1:0];
          end
        end
        ST_ACC: begin
          sum_q  <= sum_q + acc_val;
          fill_q <= fill_n;
        end
        ST_R0:   r0_q <= (rs_q == '0) ? OhmBits'(1) : rs_q;
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            sum_q       <= '0;
            fill_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_q <= s_axis_tuser;
          lvl_q  <= s_axis_tdata[ADC_BITS-1:0];
        end
      end
      ST_VS:     prod_q <= mul_p;
      ST_CLAMP:  vs_q   <= (prod_q < PW'(FullScale)) ? VW'(FullScale) : prod_q[VW-1:0];
      ST_NUM: begin
        prod_q <= mul_p;
        rs_q   <= '0;
      end
      ST_RSDIV:  if (done_q) rs_q <= dq_q[OhmBits-1:0];
      ST_R0:     conc_q <= '0;
      ST_MAPMUL: begin
        prod_q <= mul_p;
        conc_q <= '0;
      end
      ST_MAPDIV: begin
        if (done_q) conc_q <= (dq_q > DW'(ConcMax)) ? ConcBits'(ConcMax) : dq_q[ConcBits-1:0];
      end
      ST_AVG: begin
        if (done_q) begin
          if (mode_q) conc_q <= dq_q[ConcBits-1:0];
          else        lvl_q  <= dq_q[ADC_BITS-1:0];
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_kind_q <= mode_q;
          out_data_q <= OutDataBits'({ratio_q, conc_q, r0_q});
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule
`default_nettype wire

// ===== design/gsca_checker.sv =====
// checker: port-level properties of the concentration averager results
`default_nettype none
module gsca_checker
  import gsca_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OutDataBits-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled request changed");

  a_cal_conc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[46:33] == '0)
    else $error("calibration result with nonzero concentration");

  a_conc_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[46:33] <= ConcBits'(ConcMax))
    else $error("concentration out of range");

  a_r0_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:0] != '0)
    else $error("zero reference resistance");

endmodule

bind gas_sensor_concentration_averager gsca_checker u_gsca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== sim/gas_sensor_concentration_averager_tb.sv =====
// testbench: random and directed stream traffic against a behavioral predictor of the averager
`timescale 1ns / 1ps
module gas_sensor_concentration_averager_tb;
  import gsca_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [32:0] ohms;
    logic [13:0] conc;
    logic [19:0] ratio;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;

  gas_sensor_concentration_averager dut (.*);

  always #5 clk_i = ~clk_i;

  // requests waiting for the driver: {mode, adc_sample}
  logic [12:0] sample_queue[$];
  reading_t    expected_readings[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int rx_hold = 0;
  int mismatches = 0;
  int n_accepted = 0;
  int n_cal = 0;
  int n_meas = 0;
  longint cycles = 0;

  // predictor copy of registers and state
  longint unsigned p_supply, p_load, p_rz, p_rt, p_cal_cnt, p_meas_cnt;
  longint unsigned p_r0, p_sum, p_fill, p_ratio;
  logic            p_mode;

  function automatic longint unsigned resistance(longint unsigned level);
    longint unsigned vs, top;
    vs = level * p_supply;
    top = p_supply * 4095;
    if (vs < 4095) vs = 4095;
    if (top <= vs) return 0;
    return p_load * (top - vs) / vs;
  endfunction

  function automatic longint unsigned to_milligrams(longint unsigned ratio);
    longint z, span, c;
    z = longint'(p_rz);
    span = longint'(p_rt) - z;
    if (span == 0) return 0;
    c = (longint'(ratio) - z) * 10000 / span;
    if (c < 0) c = 0;
    if (c > 10000) c = 10000;
    return longint'(c);
  endfunction

  function automatic void predict_sample(logic mode, logic [11:0] sample);
    longint unsigned lim, rs, ratio, avg, r0;
    reading_t r;
    if (mode != p_mode) begin
      p_mode = mode;
      p_sum = 0;
      p_fill = 0;
    end
    if (mode == MODE_CAL) begin
      p_sum += sample;
      lim = p_cal_cnt;
    end else begin
      rs = resistance(sample);
      ratio = (rs << 12) / p_r0;
      if (ratio > 1048575) ratio = 1048575;
      p_ratio = ratio;
      p_sum += to_milligrams(ratio);
      lim = p_meas_cnt;
    end
    p_fill = (p_fill + 1) & 1023;
    if (p_fill == 0) p_fill = 1023;
    if (lim == 0) lim = 1;
    if (p_fill < lim) return;
    avg = p_sum / p_fill;
    r.conc = '0;
    if (mode == MODE_CAL) begin
      r0 = resistance(avg) & 64'h1_FFFF_FFFF;
      p_r0 = (r0 == 0) ? 1 : r0;
    end else begin
      r.conc = avg[13:0];
    end
    r.kind = mode;
    r.ohms = p_r0[32:0];
    r.ratio = p_ratio[19:0];
    expected_readings.push_back(r);
    p_sum = 0;
    p_fill = 0;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tuser, s_axis_tdata[11:0]);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tuser <= sample_queue[0][12];
          s_axis_tdata <= {4'h0, sample_queue[0][11:0]};
          s_axis_tvalid <= 1'b1;
          void'(sample_queue.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) if (rx_hold > 0) rx_hold <= rx_hold - 1;

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.ohms = m_axis_tdata[32:0];
        got.conc = m_axis_tdata[46:33];
        got.ratio = m_axis_tdata[66:47];
        if (got.kind == MODE_CAL) n_cal++; else n_meas++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want || m_axis_tdata[71:67] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      m_axis_tready <= (rx_hold == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("timeout");
      $display("gas_sensor_concentration_averager_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_SUPPLY:   p_supply = val & 20'h1FFF;
      CFG_LOAD:     p_load = val;
      CFG_RATIO_Z:  p_rz = val;
      CFG_RATIO_T:  p_rt = val;
      CFG_CAL_CNT:  p_cal_cnt = val & 20'h3FF;
      CFG_MEAS_CNT: p_meas_cnt = val & 20'h3FF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || s_axis_tvalid || expected_readings.size() > 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic send(logic mode, logic [11:0] sample);
    sample_queue.push_back({mode, sample});
  endtask

  task automatic random_setup();
    int r;
    r = $urandom_range(9);
    write_reg(CFG_SUPPLY, r == 0 ? 20'd5000 : r == 1 ? 20'd1000
                                            : 20'($urandom_range(1000, 5000)));
    r = $urandom_range(9);
    write_reg(CFG_LOAD, r == 0 ? 20'd1 : r == 1 ? 20'hFFFFF
                                       : 20'($urandom_range(1, 1000000)));
    r = $urandom_range(9);
    if (r < 6) begin
      write_reg(CFG_RATIO_Z, 20'($urandom_range(2048, 12000)));
      write_reg(CFG_RATIO_T, 20'($urandom_range(100, 2048)));
    end else if (r < 8) begin
      write_reg(CFG_RATIO_Z, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(CFG_RATIO_T, 20'($urandom_range(0, 20'hFFFFF)));
    end else begin
      write_reg(CFG_RATIO_Z, 20'd3000);
      write_reg(CFG_RATIO_T, r == 8 ? 20'd3000 : 20'd9000);
    end
    write_reg(CFG_CAL_CNT, 20'($urandom_range(0, 6)));
    write_reg(CFG_MEAS_CNT, 20'($urandom_range(0, 5)));
  endtask

  // mostly complete windows with random content, some cut short by a mode change
  task automatic random_traffic(int n);
    int len, base, spread;
    logic mode;
    while (n > 0) begin
      mode = ($urandom_range(9) < 3) ? MODE_CAL : MODE_MEAS;
      len = (mode == MODE_CAL) ? int'(p_cal_cnt) : int'(p_meas_cnt);
      if (len == 0) len = 1;
      if ($urandom_range(9) == 0) len = $urandom_range(1, len);
      base = $urandom_range(0, 4095);
      spread = $urandom_range(0, 3) == 0 ? 4095 : 200;
      repeat (len) begin
        if ($urandom_range(19) == 0)
          send(mode, $urandom_range(1) ? 12'hFFF : 12'h000);
        else
          send(mode, 12'($urandom_range(base > spread ? base - spread : 0,
                                        base + spread > 4095 ? 4095 : base + spread)));
        n--;
      end
    end
  endtask

  initial begin
    p_supply = 3300; p_load = 10000; p_rz = 4096; p_rt = 492;
    p_cal_cnt = 200; p_meas_cnt = 150;
    p_r0 = 1; p_sum = 0; p_fill = 0; p_mode = MODE_CAL; p_ratio = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: window ends, mode changes, field extremes
    write_reg(CFG_CAL_CNT, 2);
    write_reg(CFG_MEAS_CNT, 3);
    send(MODE_CAL, 12'hFFF); send(MODE_CAL, 12'h000);
    send(MODE_MEAS, 12'h000); send(MODE_MEAS, 12'hFFF); send(MODE_MEAS, 12'h800);
    send(MODE_CAL, 12'd100); send(MODE_MEAS, 12'h5A5); send(MODE_CAL, 12'h7FF);
    send(MODE_CAL, 12'h400);
    drain();
    write_reg(CFG_MEAS_CNT, 5);
    send(MODE_MEAS, 12'h300); send(MODE_MEAS, 12'hC00); send(MODE_MEAS, 12'h555);
    drain();
    // window shortened mid-window
    write_reg(CFG_MEAS_CNT, 1);
    send(MODE_MEAS, 12'hAAA);
    drain();
    write_reg(CFG_RATIO_T, 20'd4096);
    send(MODE_MEAS, 12'h123);
    drain();
    // zero window length and a sample at full scale: R0 held at one
    write_reg(CFG_CAL_CNT, 0);
    write_reg(3'd6, 20'd7);
    write_reg(3'd7, 20'hFFFFF);
    send(MODE_CAL, 12'hFFF);
    drain();
    write_reg(CFG_SUPPLY, 20'h1FFF);
    write_reg(CFG_LOAD, 20'hFFFFF);
    write_reg(CFG_RATIO_Z, 20'hFFFFF);
    write_reg(CFG_RATIO_T, 20'h00000);
    send(MODE_MEAS, 12'h000); send(MODE_MEAS, 12'h001);
    drain();
    write_reg(CFG_SUPPLY, 20'd0);
    send(MODE_CAL, 12'h200); send(MODE_MEAS, 12'h200);
    drain();
    write_reg(CFG_CAL_CNT, 1023);
    write_reg(CFG_MEAS_CNT, 1023);
    write_reg(CFG_SUPPLY, 20'd1000);
    send(MODE_CAL, 12'h321); send(MODE_CAL, 12'h0F0); send(MODE_MEAS, 12'h456);
    send(MODE_CAL, 12'hF0F);
    drain();

    // output held off while the sender keeps offering
    write_reg(CFG_SUPPLY, 20'd3300);
    write_reg(CFG_LOAD, 20'd10000);
    write_reg(CFG_RATIO_Z, 20'd4096);
    write_reg(CFG_RATIO_T, 20'd492);
    write_reg(CFG_CAL_CNT, 1);
    write_reg(CFG_MEAS_CNT, 1);
    send(MODE_CAL, 12'h600);
    drain();
    rx_hold = 3000;
    random_traffic(30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 13 : 52) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 13 : 52) : 0;
      repeat (3) begin
        random_setup();
        random_traffic(115);
        drain();
      end
    end

    $display("accepted %0d samples; checked %0d calibration and %0d concentration results",
             n_accepted, n_cal, n_meas);
    if (mismatches == 0) begin
      $display("gas_sensor_concentration_averager_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("gas_sensor_concentration_averager_tb: done, errors");
    end
    $finish;
  end

endmodule
